@@ rtl/swpt_pkg.sv @@
package swpt_pkg;

  localparam int WINDOW_DEF = 240;

  localparam int SAMPLE_W = 24;
  localparam int HYST_W   = 7;
  localparam int NEED_W   = 8;
  localparam int TICK_W   = 8;
  localparam int FILL_W   = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [SAMPLE_W-1:0] MIN_THR_RST = 24'd1500;
  localparam logic [SAMPLE_W-1:0] MAX_THR_RST = 24'd80000;
  localparam logic [SAMPLE_W-1:0] HELD_RST    = 24'd1500;
  localparam logic [HYST_W-1:0]   HYST_RST    = 7'd6;
  localparam logic [NEED_W-1:0]   NEED_RST    = 8'd60;
  localparam logic [TICK_W-1:0]   ADAPT_RST   = 8'd8;
  localparam logic [FILL_W-1:0]   FILL_CAP    = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_ON  = 3'd0,
    REG_MIN_THR  = 3'd1,
    REG_MAX_THR  = 3'd2,
    REG_HYST     = 3'd3,
    REG_NEED     = 3'd4,
    REG_ADAPT    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_AUTO_OFF = 2'd0,
    ST_NO_FEED  = 2'd1,
    ST_LEARNING = 2'd2,
    ST_ADAPTING = 2'd3
  } status_t;

endpackage

@@ rtl/swpt_cell.sv @@
module swpt_cell
  import swpt_pkg::*;
(
  input  logic                clk,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] d,
  output logic [SAMPLE_W-1:0] q
);

  logic [SAMPLE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

@@ rtl/swpt_div.sv @@
module swpt_div
  import swpt_pkg::*;
#(
  parameter int DW = 15
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [NEED_W-1:0] divisor,
  output logic              done,
  output logic [DW-1:0]     quot
);

  localparam int SW = $clog2(DW + 1);

  logic [NEED_W:0]   rem_r, rem_nxt;
  logic [DW-1:0]     sh_r, sh_nxt;
  logic [NEED_W-1:0] dv_r;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NEED_W+1:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, sh_r[DW-1]};
    if (start) begin
      rem_nxt  = '0;
      sh_nxt   = dividend;
      cnt_nxt  = SW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, dv_r}) begin
        rem_nxt = (NEED_W+1)'(trial - {2'b00, dv_r});
        sh_nxt  = {sh_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[NEED_W:0];
        sh_nxt  = {sh_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    if (start) begin
      dv_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

@@ rtl/sliding_window_percentile_threshold_unit.sv @@
// channel | dir | tdata (low bit up)                         | tuser (low bit up)
// in_     | in  | move_sample[23:0]                          | feed_live, rebaseline
// out_    | out | fill_level[6:0] baseline[30:7] thr[54:31]  | status[1:0] live pushed
// cfg_    | in  | cfg_wdata[23:0] at cfg_index               | -
// Non-evaluating tick: the sequencer stays idle. Evaluating tick: the fill divider
// runs DW = clog2(WINDOW*100+1) steps (15 at 240), then the result is offered; when
// adapting, rank select (n+1 ring turns, n = window count) and CALC1, CALC2 come between.
// Reset is synchronous; the sample cells hold no reset and are read only once written.
// Input is taken only when the sequencer is idle; a pending result stalls the sequencer.
module sliding_window_percentile_threshold_unit
  import swpt_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // move_sample
  input  logic [1:0]           in_tuser,   // feed_live, rebaseline
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,  // fill_level, baseline, threshold, pad
  output logic [3:0]           out_tuser,  // status[1:0], live_flag, pushed
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = $clog2(WINDOW);
  localparam int DW = $clog2(WINDOW * 100 + 1);
  localparam int MW = CW + 4 + 17;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_RANK  = 7'b0001000,
    S_CALC1 = 7'b0010000,
    S_CALC2 = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic                auto_r;
  logic [SAMPLE_W-1:0] min_r, max_r;
  logic [HYST_W-1:0]   hyst_r;
  logic [NEED_W-1:0]   need_r;
  logic [TICK_W-1:0]   adapt_r;

  logic [CW-1:0]       count_r, count_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [SAMPLE_W-1:0] held_r, median_r;
  logic                pushed_once_r;

  logic                live_r;
  logic [1:0]          st_r;
  logic [FILL_W-1:0]   fill_r;
  logic                push_r;

  logic                out_vld_r;
  logic [FILL_W-1:0]   o_fill_r;
  logic [SAMPLE_W-1:0] o_base_r, o_thr_r;
  logic [1:0]          o_st_r;
  logic                o_live_r, o_push_r;

  logic [SW-1:0]       step_r;
  logic [CW-1:0]       nidx_r;
  logic [SAMPLE_W-1:0] cand_r, ncand_r, ncand_f;
  logic                cand_vld_r;
  logic [CW-1:0]       below_r, upto_r, below_f, upto_f;
  logic [CW-1:0]       r50_r, r90_r;
  logic [SAMPLE_W-1:0] p50_r, p90_r;
  logic                f50_r, f90_r;
  logic [SAMPLE_W-1:0] thr_r;

  logic                accept, live_in, rebase_in, eval;
  logic [CW-1:0]       base_cnt;
  logic [TICK_W-1:0]   tick_inc;
  logic                shift_en;
  logic [SAMPLE_W-1:0] chain_d [WINDOW];
  logic [SAMPLE_W-1:0] chain_q [WINDOW];
  logic [SAMPLE_W-1:0] tap;
  logic [SW-1:0]       tap_idx;
  logic                tap_vld;
  logic                div_done;
  logic [DW-1:0]       div_quot;
  logic [DW-1:0]       div_dividend;
  logic [NEED_W-1:0]   need_eff;
  logic [MW-1:0]       r90_prod;
  logic [SAMPLE_W+1:0] thr_raw;
  logic [SAMPLE_W-1:0] thr_clamp, delta;
  logic [SAMPLE_W+7:0] lhs, rhs;
  logic                out_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign live_in   = in_tuser[0];
  assign rebase_in = in_tuser[1];
  assign out_free  = !out_vld_r || out_tready;

  assign base_cnt = rebase_in ? '0 : count_r;
  always_comb begin
    count_nxt = base_cnt;
    if (live_in && (base_cnt < CW'(WINDOW))) begin
      count_nxt = base_cnt + 1'b1;
    end
  end
  assign tick_inc = tick_r + 1'b1;
  assign eval     = !(tick_inc < adapt_r);

  // cell ring: shifts in a live sample, or rotates tail to head during rank search
  assign tap      = chain_q[WINDOW-1];
  assign shift_en = (accept && live_in) || (state_r == S_RANK);
  assign chain_d[0] = (state_r == S_RANK) ? tap : in_tdata;

  genvar g;
  generate
    for (g = 1; g < WINDOW; g++) begin : g_link
      assign chain_d[g] = chain_q[g-1];
    end
    for (g = 0; g < WINDOW; g++) begin : g_cell
      swpt_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (chain_d[g]),
        .q     (chain_q[g])
      );
    end
  endgenerate

  assign need_eff     = (need_r == '0) ? NEED_W'(1) : need_r;
  assign div_dividend = DW'(count_nxt * 7'd100);

  swpt_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && eval),
    .dividend (div_dividend),
    .divisor  (need_eff),
    .done     (div_done),
    .quot     (div_quot)
  );

  // rank search: tap shows the sample of age WINDOW-1-step
  assign tap_idx = SW'(WINDOW - 1) - step_r;
  assign tap_vld = CW'(tap_idx) < count_r;
  always_comb begin
    below_f = below_r;
    upto_f  = upto_r;
    if (cand_vld_r && tap_vld) begin
      below_f = below_r + CW'(tap < cand_r);
      upto_f  = upto_r + CW'(tap <= cand_r);
    end
    ncand_f = (CW'(tap_idx) == nidx_r) ? tap : ncand_r;
  end

  // n*9/10 through a reciprocal, exact for this range
  assign r90_prod = MW'((count_r * 4'd9) * 17'd52429);

  assign thr_raw = {2'b00, p90_r} + {1'b0, (p90_r - p50_r), 1'b0};
  always_comb begin
    thr_clamp = thr_raw[SAMPLE_W-1:0];
    if (thr_raw < {2'b00, min_r}) thr_clamp = min_r;
    if (thr_clamp > max_r || thr_raw[SAMPLE_W+1:SAMPLE_W] != 2'b00) thr_clamp = max_r;
    if (thr_raw < {2'b00, min_r} && min_r <= max_r) thr_clamp = min_r;
  end

  assign delta = (thr_r > held_r) ? thr_r - held_r : held_r - thr_r;
  assign lhs   = (SAMPLE_W+8)'(delta * 7'd100);
  assign rhs   = (SAMPLE_W+8)'(held_r * hyst_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && eval) state_nxt = S_DIV;
      S_DIV:   if (div_done) begin
        if (!auto_r || !live_r || (32'(count_r) < 32'(need_r)))
          state_nxt = S_OUT;
        else
          state_nxt = S_RANK;
      end
      S_WAIT:  state_nxt = S_RANK;
      S_RANK:  if (step_r == SW'(WINDOW - 1) && nidx_r >= count_r) state_nxt = S_CALC1;
      S_CALC1: state_nxt = S_CALC2;
      S_CALC2: state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      auto_r        <= 1'b1;
      min_r         <= MIN_THR_RST;
      max_r         <= MAX_THR_RST;
      hyst_r        <= HYST_RST;
      need_r        <= NEED_RST;
      adapt_r       <= ADAPT_RST;
      count_r       <= '0;
      tick_r        <= '0;
      held_r        <= HELD_RST;
      median_r      <= '0;
      pushed_once_r <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_AUTO_ON: auto_r  <= cfg_wdata[0];
          REG_MIN_THR: min_r   <= cfg_wdata;
          REG_MAX_THR: max_r   <= cfg_wdata;
          REG_HYST:    hyst_r  <= cfg_wdata[HYST_W-1:0];
          REG_NEED:    need_r  <= cfg_wdata[NEED_W-1:0];
          REG_ADAPT:   adapt_r <= cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        count_r <= count_nxt;
        tick_r  <= eval ? '0 : tick_inc;
        if (rebase_in) pushed_once_r <= 1'b0;
      end
      if (state_r == S_CALC1) median_r <= p50_r;
      if (state_r == S_CALC2 && (!pushed_once_r || lhs > rhs)) begin
        pushed_once_r <= 1'b1;
        held_r        <= thr_r;
      end
      if (state_r == S_OUT && out_free) out_vld_r <= 1'b1;
      else if (out_tready)              out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && eval) begin
      live_r <= live_in;
      push_r <= 1'b0;
    end
    if (state_r == S_DIV && div_done) begin
      fill_r <= (div_quot > DW'(FILL_CAP)) ? FILL_CAP : div_quot[FILL_W-1:0];
      if (!auto_r)      st_r <= ST_AUTO_OFF;
      else if (!live_r) st_r <= ST_NO_FEED;
      else              st_r <= ST_LEARNING;
      step_r     <= '0;
      nidx_r     <= '0;
      cand_vld_r <= 1'b0;
      below_r    <= '0;
      upto_r     <= '0;
      p50_r      <= '0;
      p90_r      <= '0;
      f50_r      <= 1'b0;
      f90_r      <= 1'b0;
      r50_r      <= count_r >> 1;
      r90_r      <= CW'(r90_prod >> 19);
    end
    if (state_r == S_RANK) begin
      ncand_r <= ncand_f;
      if (step_r == SW'(WINDOW - 1)) begin
        step_r <= '0;
        if (cand_vld_r) begin
          if (!f50_r && below_f <= r50_r && r50_r < upto_f) begin
            p50_r <= cand_r;
            f50_r <= 1'b1;
          end
          if (!f90_r && below_f <= r90_r && r90_r < upto_f) begin
            p90_r <= cand_r;
            f90_r <= 1'b1;
          end
        end
        cand_r     <= ncand_f;
        cand_vld_r <= nidx_r < count_r;
        nidx_r     <= nidx_r + 1'b1;
        below_r    <= '0;
        upto_r     <= '0;
      end else begin
        step_r  <= step_r + 1'b1;
        below_r <= below_f;
        upto_r  <= upto_f;
      end
    end
    if (state_r == S_CALC1) thr_r <= thr_clamp;
    if (state_r == S_CALC2) begin
      st_r   <= ST_ADAPTING;
      push_r <= !pushed_once_r || lhs > rhs;
    end
    if (state_r == S_OUT && out_free) begin
      o_st_r   <= st_r;
      o_live_r <= live_r;
      o_fill_r <= fill_r;
      o_push_r <= push_r;
      o_base_r <= median_r;
      o_thr_r  <= held_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, o_thr_r, o_base_r, o_fill_r};
  assign out_tuser  = {o_push_r, o_live_r, o_st_r};

endmodule

@@ rtl/swpt_checker.sv @@
module swpt_checker
  import swpt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [3:0]  out_tuser
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_push_only_adapt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_ADAPTING |-> !out_tuser[3])
    else $error("push flagged outside adapting status");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] <= FILL_CAP && !out_tdata[55])
    else $error("fill above cap or pad bit set");

endmodule

bind sliding_window_percentile_threshold_unit swpt_checker u_swpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
